/* sv/assert_macros.svh */
// assertion macros used by the bloom filter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bfd_pkg.sv */
// types and constants of the djb2 bloom filter
package bfd_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int CFG_W       = 13;
    localparam int DIV_W       = $clog2(STORE_BYTES + 1);
    localparam int HASH_W      = 32;
    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    // remainder unit: bits of the dividend retired per cycle
    localparam int DIV_STEPS   = 4;
    localparam int DVD_BITS    = HASH_W - 3;
    localparam int DIV_ITERS   = (DVD_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DVD_W       = DIV_ITERS * DIV_STEPS;
    localparam int CNT_W       = $clog2(DIV_ITERS);

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_TEST = 2'd1,
        CMD_LOAD = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  text_byte;
        logic        word_last;
        logic [11:0] load_index;
        logic [7:0]  load_byte;
    } t_in;

    typedef struct packed {
        logic        maybe_present;
        logic [14:0] bit_position;
    } t_out;

endpackage

/* sv/bloom_filter_djb2.sv */
// top level of the djb2 bloom filter: hashing, remainder unit and bit store control
//
// input channel (i_in_valid / o_in_stall, payload t_in): one byte of a word per
// transfer, word_last on its final byte. add and test bytes fold into the djb2
// hash (hash*33 + byte); a load writes one store byte. on the final byte the
// hash is reduced modulo filter_bytes*8 by an iterative remainder unit retiring
// four bits a cycle, then the store byte is read and either updated (add) or
// reported (test). the input is stalled from a final byte until its add or test
// completes; other bytes and loads do not stall it. a test result appears on
// the output channel (o_out_valid / i_out_stall, payload t_out) after the
// reduction, the store read and the wait state.
// the output is a register: a waiting result does not block hashing bytes; only
// a second test result waits (input stalled) until the first has been taken.
// config channel (i_cfg_valid / o_cfg_ready) writes filter_bytes; values below 1
// or above the store size are clamped. write it only while the block is idle.
// after reset the store is cleared one byte a cycle, all 4096 bytes, with the
// input stalled; config writes are taken meanwhile.
module bloom_filter_djb2 import bfd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_READ  = 5'b01000,
        ST_WAIT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [CFG_W-1:0]    r_cfg;
    logic [STORE_AW-1:0] r_clr_addr, n_clr_addr;
    logic [DVD_W-1:0]    r_dvd, n_dvd;
    logic [STORE_AW-1:0] r_rem, n_rem;
    logic [DIV_W-1:0]    r_div, n_div;
    logic [2:0]          r_lo3, n_lo3;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_is_add, n_is_add;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic                in_xfer;
    logic                hashing;
    logic [HASH_W-1:0]   hash_upd;
    logic [DIV_W-1:0]    used_bytes;
    logic [STORE_AW:0]   div_trial;
    logic [STORE_AW-1:0] div_rem;
    logic                out_free;
    logic [7:0]          bit_mask;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [7:0]          ram_wdata;
    logic [7:0]          ram_rdata;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign hashing  = (i_in_data.command == CMD_ADD) || (i_in_data.command == CMD_TEST);
    // djb2 step, wraps at 32 bits
    assign hash_upd = (r_hash << 5) + r_hash + HASH_W'(i_in_data.text_byte);
    assign out_free = !r_out_valid || !i_out_stall;
    assign bit_mask = 8'(1) << r_lo3;

    // clamp the configured size into the store
    always_comb begin
        if (r_cfg == '0) begin
            used_bytes = DIV_W'(1);
        end else if (32'(r_cfg) > STORE_BYTES) begin
            used_bytes = DIV_W'(STORE_BYTES);
        end else begin
            used_bytes = DIV_W'(r_cfg);
        end
    end

    // four restoring remainder steps per cycle, top dividend bits first
    always_comb begin
        div_rem   = r_rem;
        div_trial = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            div_trial = {div_rem, r_dvd[DVD_W-1-i]};
            if (div_trial >= (STORE_AW+1)'(r_div)) begin
                div_trial = div_trial - (STORE_AW+1)'(r_div);
            end
            div_rem = div_trial[STORE_AW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_clr_addr  = r_clr_addr;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_div       = r_div;
        n_lo3       = r_lo3;
        n_cnt       = r_cnt;
        n_is_add    = r_is_add;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_rem;
        ram_wdata   = ram_rdata | bit_mask;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == STORE_AW'(STORE_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.command == CMD_LOAD) begin
                        ram_we    = (32'(i_in_data.load_index) < STORE_BYTES);
                        ram_waddr = STORE_AW'(i_in_data.load_index);
                        ram_wdata = i_in_data.load_byte;
                    end else if (hashing) begin
                        if (i_in_data.word_last) begin
                            // bit index = ((h>>3) mod n)*8 + h[2:0]
                            n_hash   = HASH_SEED;
                            n_dvd    = DVD_W'(hash_upd[HASH_W-1:3]);
                            n_lo3    = hash_upd[2:0];
                            n_rem    = '0;
                            n_div    = used_bytes;
                            n_cnt    = '0;
                            n_is_add = (i_in_data.command == CMD_ADD);
                            n_state  = ST_DIV;
                        end else begin
                            n_hash = hash_upd;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_rem = div_rem;
                n_dvd = r_dvd << DIV_STEPS;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_ITERS - 1)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // store byte at r_rem is being read
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (r_is_add) begin
                    ram_we  = 1'b1;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.maybe_present = ram_rdata[r_lo3];
                    n_out.bit_position  = {r_rem, r_lo3};
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_hash      <= HASH_SEED;
            r_cfg       <= CFG_W'(STORE_BYTES);
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_lo3    <= n_lo3;
        r_cnt    <= n_cnt;
        r_is_add <= n_is_add;
        r_out    <= n_out;
    end

    bfd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (r_rem),
        .o_rd_data (ram_rdata)
    );

    // no result can appear while the store is being cleared
    `BFD_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, r_state == ST_CLEAR, !r_out_valid, "result during clear")
    // remainder stays below the divisor throughout the reduction
    `BFD_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, r_state == ST_DIV, (DIV_W+1)'(r_rem) < (DIV_W+1)'(r_div), "remainder out of range")
    // divisor is a clamped, nonzero size
    `BFD_ASSERT_IMP(a_div_range, i_clk, i_rst_n, r_state == ST_DIV, (r_div != '0) && (32'(r_div) <= STORE_BYTES), "divisor out of range")
    // reduction moves to the read once the iteration count reaches its last value
    `BFD_ASSERT_NXT(a_div_done, i_clk, i_rst_n, (r_state == ST_DIV) && (r_cnt == CNT_W'(DIV_ITERS - 1)), r_state == ST_READ, "reduction did not finish")

endmodule

/* sv/bfd_ram.sv */
// generic single-port-write, registered-read ram
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
